// ===== rtl/tgard_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
package tgard_pkg;

    localparam int DIM_W     = 13;   // image_width / image_height register width
    localparam int LIM_W     = 16;   // width of the size limit parameters
    localparam int TOTAL_W   = 26;   // pixels in the largest image, 8191 * 8191
    localparam int INDEX_W   = 24;   // start_index port width
    localparam int CFG_DW    = 13;   // configuration write data width
    localparam int CFG_IW    = 2;    // configuration register index width
    localparam int RUN_BIT   = 7;    // packet header: run flag
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_IW-1:0] {
        CFG_RLE_MODE   = 2'd0,
        CFG_FOUR_BYTE  = 2'd1,
        CFG_WIDTH      = 2'd2,
        CFG_HEIGHT     = 2'd3
    } cfg_reg_t;

    // Settings seen by the front end
    typedef struct packed {
        logic               rle_mode;
        logic               four_byte;
        logic [TOTAL_W-1:0] total;
    } dec_cfg_t;

    // One completed pixel, queued between front and back
    typedef struct packed {
        logic [23:0]        partial;
        logic [7:0]         last_byte;
        logic [1:0]         phase;
        logic               four_byte;
        logic [7:0]         count;
        logic [INDEX_W-1:0] start;
        logic               done;
    } pix_cmd_t;

endpackage

// ===== rtl/tga_rle_pixel_decoder_core.sv =====
// TGA RLE / raw pixel decoder top level (24 and 32 bit pixels).
// One body byte per cycle while the queue has room; at most one result per pixel.
// The byte that completes a pixel is written into the two-entry queue; its result
// beat then moves to the output register, which drives the output.
// Reset (rst_n, async, low): decode state cleared, queue empty, registers back to
// RLE mode, 32-bit pixels and a 1 x 1 image. No clearing pass.
module tga_rle_pixel_decoder_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // body byte beats
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          first_of_image,
    // result beats
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   pixel_word,
    output logic [7:0]                    repeat_count,
    output logic [23:0]                   start_index,
    output logic                          image_done,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [tgard_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [tgard_pkg::CFG_DW-1:0]  cfg_data
);
    import tgard_pkg::*;

    localparam logic [LIM_W-1:0] LIM_W_MAX = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] LIM_H_MAX = LIM_W'(MAX_HEIGHT);

    // Sizes are saturated to 1..MAX; result never exceeds the 13-bit input.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [LIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if ({{(LIM_W-DIM_W){1'b0}}, v} > lim)
            r = lim[DIM_W-1:0];
        else
            r = v;
        return r;
    endfunction

    // Configuration registers
    logic               rle_mode_reg;
    logic               four_byte_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    // Pixel total kept registered so the front end never sees the multiplier.
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [DIM_W-1:0]   w_clamped, h_clamped;

    always_comb
    begin
        w_clamped = clamp_dim(width_reg, LIM_W_MAX);
        h_clamped = clamp_dim(height_reg, LIM_H_MAX);
        if (cfg_we && cfg_reg_t'(cfg_index) == CFG_WIDTH)
            w_clamped = clamp_dim(cfg_data[DIM_W-1:0], LIM_W_MAX);
        if (cfg_we && cfg_reg_t'(cfg_index) == CFG_HEIGHT)
            h_clamped = clamp_dim(cfg_data[DIM_W-1:0], LIM_H_MAX);
        total_next = TOTAL_W'(w_clamped) * TOTAL_W'(h_clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg  <= 1'b1;
            four_byte_reg <= 1'b1;
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            total_reg     <= TOTAL_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_RLE_MODE:  rle_mode_reg  <= cfg_data[0];
                CFG_FOUR_BYTE: four_byte_reg <= cfg_data[0];
                CFG_WIDTH:     width_reg     <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    height_reg    <= cfg_data[DIM_W-1:0];
            endcase
            total_reg <= total_next;
        end
    end

    dec_cfg_t cfg;
    assign cfg.rle_mode  = rle_mode_reg;
    assign cfg.four_byte = four_byte_reg;
    assign cfg.total     = total_reg;

    // Front: packet headers, byte gathering, run clipping and pixel count.
    pix_cmd_t front_cmd, back_cmd;
    logic     push, pop, q_full, q_empty;

    tgard_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .first_of_image (first_of_image),
        .cfg            (cfg),
        .q_full         (q_full),
        .push           (push),
        .cmd            (front_cmd)
    );

    // Short queue: front keeps taking bytes while a result waits at the output.
    tgard_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .pop_data  (back_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: pixel word assembly, alpha fill for 24-bit, output register.
    tgard_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (back_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_word   (pixel_word),
        .repeat_count (repeat_count),
        .start_index  (start_index),
        .image_done   (image_done)
    );

endmodule

// ===== rtl/tgard_front.sv =====
// Front end: takes body bytes, tracks packets and pixel count, issues pixel commands.
module tgard_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                first_of_image,
    input  tgard_pkg::dec_cfg_t cfg,
    input  logic                q_full,
    output logic                push,
    output tgard_pkg::pix_cmd_t cmd
);
    import tgard_pkg::*;

    logic [7:0]         pl_reg, pl_next, pl_e;
    logic               run_reg, run_next, run_e;
    logic [1:0]         phase_reg, phase_next, phase_e;
    logic [23:0]        partial_reg, partial_next, partial_e;
    logic [TOTAL_W-1:0] index_reg, index_next, index_e;
    logic               fin_reg, fin_next, fin_e;

    logic               accept;
    logic [TOTAL_W:0]   diff;
    logic [TOTAL_W-1:0] left;
    logic [1:0]         last_phase;
    logic [7:0]         run_count;
    logic [7:0]         count;

    assign in_ready = ~q_full;
    assign accept   = in_valid & ~q_full;

    always_comb
    begin
        // a new image clears everything before the beat is used
        pl_e      = first_of_image ? 8'd0 : pl_reg;
        run_e     = first_of_image ? 1'b0 : run_reg;
        phase_e   = first_of_image ? 2'd0 : phase_reg;
        partial_e = first_of_image ? 24'd0 : partial_reg;
        index_e   = first_of_image ? '0 : index_reg;
        fin_e     = first_of_image ? 1'b0 : fin_reg;

        diff       = {1'b0, cfg.total} - {1'b0, index_e};
        left       = diff[TOTAL_W] ? '0 : diff[TOTAL_W-1:0];
        last_phase = cfg.four_byte ? 2'd3 : 2'd2;
        run_count  = ({{(TOTAL_W-8){1'b0}}, pl_e} > left) ? left[7:0] : pl_e;
        count      = (cfg.rle_mode && run_e) ? run_count : 8'd1;

        pl_next      = pl_e;
        run_next     = run_e;
        phase_next   = phase_e;
        partial_next = partial_e;
        index_next   = index_e;
        fin_next     = fin_e;
        push         = 1'b0;

        if (!fin_e)
        begin
            if (left == '0)
            begin
                fin_next = 1'b1;
            end
            else if (cfg.rle_mode && pl_e == 8'd0)
            begin
                run_next     = data_byte[RUN_BIT];
                pl_next      = {1'b0, data_byte[6:0]} + 8'd1;
                phase_next   = 2'd0;
                partial_next = 24'd0;
            end
            else if (phase_e < last_phase)
            begin
                unique case (phase_e)
                    2'd0: partial_next[7:0]   = partial_e[7:0] | data_byte;
                    2'd1: partial_next[15:8]  = partial_e[15:8] | data_byte;
                    2'd2: partial_next[23:16] = partial_e[23:16] | data_byte;
                    2'd3: partial_next        = partial_e;
                endcase
                phase_next = phase_e + 2'd1;
            end
            else
            begin
                push         = accept;
                phase_next   = 2'd0;
                partial_next = 24'd0;
                if (cfg.rle_mode)
                begin
                    pl_next = run_e ? 8'd0 : pl_e - 8'd1;
                end
                index_next = index_e + {{(TOTAL_W-8){1'b0}}, count};
                fin_next   = ({{(TOTAL_W-8){1'b0}}, count} == left);
            end
        end

        cmd.partial   = partial_e;
        cmd.last_byte = data_byte;
        cmd.phase     = phase_e;
        cmd.four_byte = cfg.four_byte;
        cmd.count     = count;
        cmd.start     = index_e[INDEX_W-1:0];
        cmd.done      = fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_reg      <= 8'd0;
            run_reg     <= 1'b0;
            phase_reg   <= 2'd0;
            partial_reg <= 24'd0;
            index_reg   <= '0;
            fin_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pl_reg      <= pl_next;
            run_reg     <= run_next;
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            index_reg   <= index_next;
            fin_reg     <= fin_next;
        end
    end

endmodule

// ===== rtl/tgard_fifo.sv =====
// Two-entry command queue between front and back end.
module tgard_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tgard_pkg::pix_cmd_t push_data,
    input  logic                pop,
    output tgard_pkg::pix_cmd_t pop_data,
    output logic                full,
    output logic                empty
);
    import tgard_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    pix_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/tgard_back.sv =====
// Back end: assembles the pixel word and holds the result in the output register.
module tgard_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  tgard_pkg::pix_cmd_t q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         pixel_word,
    output logic [7:0]          repeat_count,
    output logic [23:0]         start_index,
    output logic                image_done
);
    import tgard_pkg::*;

    logic               valid_reg;
    logic [31:0]        word_reg, word_next;
    logic [7:0]         count_reg;
    logic [INDEX_W-1:0] start_reg;
    logic               done_reg;

    assign pop = ~q_empty & (~valid_reg | out_ready);

    always_comb
    begin
        word_next = {8'h00, q_data.partial};
        // last byte lands at the lane the gather had reached
        unique case (q_data.phase)
            2'd0: word_next[7:0]   = word_next[7:0] | q_data.last_byte;
            2'd1: word_next[15:8]  = word_next[15:8] | q_data.last_byte;
            2'd2: word_next[23:16] = word_next[23:16] | q_data.last_byte;
            2'd3: word_next[31:24] = q_data.last_byte;
        endcase
        if (!q_data.four_byte)
            word_next[31:24] = ALPHA_OPAQUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg  <= word_next;
            count_reg <= q_data.count;
            start_reg <= q_data.start;
            done_reg  <= q_data.done;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_word   = word_reg;
    assign repeat_count = count_reg;
    assign start_index  = start_reg;
    assign image_done   = done_reg;

endmodule

// ===== rtl/tgard_checker.sv =====
// Port-level checks for the TGA RLE decoder, bound to the top level.
module tgard_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pixel_word,
    input logic [7:0]  repeat_count,
    input logic [23:0] start_index
);

    // result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before accept");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_word) && $stable(start_index)
                                    && $stable(repeat_count))
        else $error("result payload changed while stalled");

    // queue only fills up behind a stalled output
    a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with output register empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (repeat_count != 8'd0) && (repeat_count <= 8'd128))
        else $error("repeat count out of range");

endmodule

bind tga_rle_pixel_decoder_core tgard_checker u_tgard_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_word   (pixel_word),
    .repeat_count (repeat_count),
    .start_index  (start_index)
);
